// File: hw/rtl/dlpm_pkg.sv
// Shared types and constants for the DFA longest-prefix matcher.
// No dependencies; imported by every module of the block except dlpm_ram.
package dlpm_pkg;

  // Field widths fixed by the item format
  localparam int OP_W     = 2;
  localparam int STATE_W  = 6;
  localparam int SYMBOL_W = 8;
  localparam int OUT_W    = 16;
  localparam int ENTRY_W  = STATE_W + 1;   // valid bit over next state
  localparam int IN_DATA_W = 24;           // 21 field bits padded to bytes
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Default sizes
  localparam int DEF_STATE_COUNT  = 64;
  localparam int DEF_SYMBOL_COUNT = 128;
  localparam int DEF_LENGTH_BITS  = 16;

  // Register index taken from paddr[2]
  localparam logic REG_START = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_WR_TRANS  = 2'd0,
    OP_WR_ACCEPT = 2'd1,
    OP_MATCH     = 2'd2,
    OP_FINISH    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ACC
  } fsm_t;

  typedef struct packed {
    logic active;
    logic last;
  } sweep_stat_t;

endpackage

// File: hw/rtl/dlpm_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; used for the transition table and the accept flags.
module dlpm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/dlpm_sweep.sv
// Post-reset clearing sweep: walks every table address once, one per cycle.
// Depends on dlpm_pkg for the status struct.
module dlpm_sweep #(
  parameter int DEPTH = 8192
) (
  input  logic                        clk,
  input  logic                        rst,
  output dlpm_pkg::sweep_stat_t       stat,
  output logic [$clog2(DEPTH)-1:0]    addr
);
  import dlpm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      addr   <= '0;
    end else if (active) begin
      if (addr == LAST_ADDR) begin
        active <= 1'b0;
      end else begin
        addr <= addr + 1'b1;
      end
    end
  end

  assign stat.active = active;
  assign stat.last   = active && (addr == LAST_ADDR);

endmodule

// File: hw/rtl/dfa_longest_prefix_match_core.sv
// Top level of the DFA longest-prefix matcher: control FSM, run registers,
// output register, APB register. Uses dlpm_pkg, dlpm_ram, dlpm_sweep.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+-----------------------------------
//  s_axis   | in  | tvalid/tready               | tuser: operation; tdata: see port
//  m_axis   | out | tvalid/tready               | tdata: match_length
//  apb      | in  | psel/penable/pwrite, pready | reg 0 @0x0: start register [5:0]
//
// Item handling: writes, finish and bytes of a dead run or with a bad symbol are taken in
// IDLE alone; a match byte that hits a missing transition (or reaches a state with no
// accept flag entry) also passes through LOOK; a live step passes through LOOK and ACC,
// for the table read followed by the accept-flag read, both through registered RAM ports.
// After reset a clearing sweep writes every table entry (STATE_COUNT*SYMBOL_COUNT
// entries, 8192 by default) and the accept flags; s_axis_tready stays low meanwhile.
// A finish waits only while the output register is full and not being taken; other
// items keep flowing while a result waits.
module dfa_longest_prefix_match_core #(
  parameter int STATE_COUNT  = dlpm_pkg::DEF_STATE_COUNT,
  parameter int SYMBOL_COUNT = dlpm_pkg::DEF_SYMBOL_COUNT,
  parameter int LENGTH_BITS  = dlpm_pkg::DEF_LENGTH_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [5:0] state_index, [13:6] symbol, [19:14] next_state, [20] entry_valid, [23:21] zero
  input  logic [dlpm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  logic [dlpm_pkg::OP_W-1:0]     s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] match_length
  output logic [dlpm_pkg::OUT_W-1:0]    m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dlpm_pkg::APB_AW-1:0]   paddr,
  input  logic [dlpm_pkg::APB_DW-1:0]   pwdata,
  output logic [dlpm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import dlpm_pkg::*;

  localparam int TDEPTH = STATE_COUNT * SYMBOL_COUNT;
  localparam int TAW    = $clog2(TDEPTH);
  // only 6-bit state numbers can ever be addressed
  localparam int ADEPTH = (STATE_COUNT < (1 << STATE_W)) ? STATE_COUNT : (1 << STATE_W);
  localparam int AAW    = $clog2(ADEPTH);

  // input field unpack
  op_t                 in_op;
  logic [STATE_W-1:0]  in_state;
  logic [SYMBOL_W-1:0] in_symbol;
  logic [STATE_W-1:0]  in_next;
  logic                in_valid;

  assign in_op     = op_t'(s_axis_tuser);
  assign in_state  = s_axis_tdata[5:0];
  assign in_symbol = s_axis_tdata[13:6];
  assign in_next   = s_axis_tdata[19:14];
  assign in_valid  = s_axis_tdata[20];

  // run state
  fsm_t                   state, state_next;
  logic [STATE_W-1:0]     run_start;
  logic [STATE_W-1:0]     cur, cur_next;
  logic                   dead, dead_next;
  logic [LENGTH_BITS-1:0] bytes, bytes_next;
  logic [LENGTH_BITS-1:0] best, best_next;
  logic                   out_valid, out_valid_next;
  logic [OUT_W-1:0]       out_data, out_data_next;

  // memory ports
  logic               t_we, t_re;
  logic [TAW-1:0]     t_waddr, t_raddr;
  logic [ENTRY_W-1:0] t_wdata, t_rdata;
  logic               a_we, a_re;
  logic [AAW-1:0]     a_waddr, a_raddr;
  logic               a_wdata, a_rdata;

  sweep_stat_t    sweep;
  logic [TAW-1:0] sweep_addr;

  logic in_fire, cfg_wr, sym_ok_in, st_ok_in, cur_ok;

  dlpm_sweep #(.DEPTH(TDEPTH)) u_sweep (
    .clk  (clk),
    .rst  (rst),
    .stat (sweep),
    .addr (sweep_addr)
  );

  dlpm_ram #(.DEPTH(TDEPTH), .WIDTH(ENTRY_W)) u_trans (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  dlpm_ram #(.DEPTH(ADEPTH), .WIDTH(1)) u_accept (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Ready only in IDLE, so a table/flag write never meets a pending read of
  // the same RAM: no forwarding needed.
  assign s_axis_tready = (state == ST_IDLE) && !sweep.active &&
                         ((in_op != OP_FINISH) || !out_valid || m_axis_tready);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START);
  assign prdata = (paddr[2] == REG_START) ? APB_DW'(run_start) : '0;

  assign sym_ok_in = (in_symbol != '0) && (int'(in_symbol) < SYMBOL_COUNT);
  assign st_ok_in  = int'(in_state) < STATE_COUNT;
  assign cur_ok    = int'(cur) < STATE_COUNT;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      run_start <= '0;
      cur       <= '0;
      dead      <= 1'b0;
      bytes     <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      dead      <= dead_next;
      bytes     <= bytes_next;
      best      <= best_next;
      out_valid <= out_valid_next;
      if (cfg_wr) begin
        run_start <= pwdata[STATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    dead_next      = dead;
    bytes_next     = bytes;
    best_next      = best;
    out_valid_next = out_valid && !m_axis_tready;
    out_data_next  = out_data;

    t_we    = 1'b0;
    t_waddr = TAW'(int'(in_state) * SYMBOL_COUNT + int'(in_symbol));
    t_wdata = in_valid ? {1'b1, in_next} : '0;
    t_re    = 1'b0;
    t_raddr = TAW'(int'(cur) * SYMBOL_COUNT + int'(in_symbol));
    a_we    = 1'b0;
    a_waddr = in_state[AAW-1:0];
    a_wdata = in_valid;
    a_re    = 1'b0;
    a_raddr = t_rdata[AAW-1:0];

    if (sweep.active) begin
      // clear pass: entries invalid, flags zero
      t_we    = 1'b1;
      t_waddr = sweep_addr;
      t_wdata = '0;
      a_we    = int'(sweep_addr) < ADEPTH;
      a_waddr = sweep_addr[AAW-1:0];
      a_wdata = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_WR_TRANS: begin
              t_we = st_ok_in && sym_ok_in;
            end
            OP_WR_ACCEPT: begin
              a_we = int'(in_state) < ADEPTH;
            end
            OP_MATCH: begin
              if (!dead) begin
                if (!cur_ok || !sym_ok_in) begin
                  dead_next = 1'b1;
                end else begin
                  t_re       = 1'b1;
                  state_next = ST_LOOK;
                end
              end
            end
            OP_FINISH: begin
              out_valid_next = 1'b1;
              out_data_next  = OUT_W'(best);
              cur_next       = run_start;
              dead_next      = 1'b0;
              bytes_next     = '0;
              best_next      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOK: begin
        if (!t_rdata[ENTRY_W-1]) begin
          dead_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cur_next = t_rdata[STATE_W-1:0];
          if (bytes != {LENGTH_BITS{1'b1}}) begin
            bytes_next = bytes + 1'b1;
          end
          // target beyond the flag store never accepts
          if (int'(t_rdata[STATE_W-1:0]) < ADEPTH) begin
            a_re       = 1'b1;
            state_next = ST_ACC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ACC: begin
        if (a_rdata) begin
          best_next = bytes;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // start register write rewinds the run
    if (cfg_wr) begin
      cur_next   = pwdata[STATE_W-1:0];
      dead_next  = 1'b0;
      bytes_next = '0;
      best_next  = '0;
    end
  end

endmodule

// File: hw/rtl/dlpm_checker.sv
// Port-level checks for the DFA matcher top, attached by bind below.
// Depends on dlpm_pkg and dfa_longest_prefix_match_core.
module dlpm_port_checks (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [dlpm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input logic [dlpm_pkg::OP_W-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [dlpm_pkg::OUT_W-1:0]     m_axis_tdata
);
  import dlpm_pkg::*;

  logic fin_fire;
  assign fin_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_FINISH);

  // clearing sweep holds off input right after reset
  a_sweep_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("input ready right after reset");

  // a finish transfer always loads the output register
  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> m_axis_tvalid)
    else $error("finish without result");

  // results appear only from a finish
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(fin_fire))
    else $error("result without finish");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind dfa_longest_prefix_match_core dlpm_port_checks u_dlpm_port_checks (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/dlpm_checker.sv
// Scoreboard for the DFA longest-prefix matcher: tracks the table, accept flags and run registers,
// predicts match_length on every finish and checks m_axis and APB reads. Uses dlpm_pkg.
module dlpm_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [dlpm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [dlpm_pkg::OP_W-1:0]      s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [dlpm_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dlpm_pkg::APB_AW-1:0]    paddr,
  input  logic [dlpm_pkg::APB_DW-1:0]    pwdata,
  input  logic [dlpm_pkg::APB_DW-1:0]    prdata,
  input  logic                           pready,
  output int                             errors,
  output int                             pending,
  output int                             lengths_checked
);
  import dlpm_pkg::*;

  localparam int N_STATES  = DEF_STATE_COUNT;
  localparam int N_SYMBOLS = DEF_SYMBOL_COUNT;
  localparam int TIDX_W    = $clog2(N_STATES * N_SYMBOLS);
  localparam logic [OUT_W-1:0] LEN_SAT = '1;  // 2^16 - 1 with the default length width

  logic [ENTRY_W-1:0] trans_mem [N_STATES*N_SYMBOLS];
  bit                 accept_mem [N_STATES];
  logic [STATE_W-1:0] start_cfg;
  logic [STATE_W-1:0] cur_state;
  bit                 run_dead;
  logic [OUT_W-1:0]   consumed;
  logic [OUT_W-1:0]   best_len;
  logic [OUT_W-1:0]   length_q [$];
  logic [OUT_W-1:0]   want_len;

  function automatic bit symbol_ok(input logic [SYMBOL_W-1:0] sym);
    return sym != 0 && sym < N_SYMBOLS;
  endfunction

  task automatic rewind_run();
    cur_state = start_cfg;
    run_dead  = 1'b0;
    consumed  = '0;
    best_len  = '0;
  endtask

  task automatic apply_item(input op_t op, input logic [STATE_W-1:0] st,
                            input logic [SYMBOL_W-1:0] sym, input logic [STATE_W-1:0] nxt,
                            input logic valid);
    logic [ENTRY_W-1:0] entry;
    case (op)
      OP_WR_TRANS: begin
        // byte zero and bytes past the alphabet never get an entry
        if (symbol_ok(sym))
          trans_mem[TIDX_W'(st*N_SYMBOLS + sym)] = valid ? {1'b1, nxt} : '0;
      end
      OP_WR_ACCEPT: begin
        accept_mem[st] = valid;
      end
      OP_MATCH: begin
        if (!run_dead) begin
          if (!symbol_ok(sym)) begin
            run_dead = 1'b1;
          end else begin
            entry = trans_mem[TIDX_W'(cur_state*N_SYMBOLS + sym)];
            if (!entry[STATE_W]) begin
              run_dead = 1'b1;
            end else begin
              cur_state = entry[STATE_W-1:0];
              if (consumed != LEN_SAT)
                consumed++;
              if (accept_mem[cur_state])
                best_len = consumed;
            end
          end
        end
      end
      default: begin
        length_q.push_back(best_len);
        rewind_run();
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (trans_mem[i]) trans_mem[i] = '0;
      foreach (accept_mem[i]) accept_mem[i] = 1'b0;
      start_cfg = '0;
      rewind_run();
      length_q.delete();
    end else begin
      // result side first: a finish taken this edge cannot be answered at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (length_q.size() == 0) begin
          errors++;
          $error("match_length: expected none, actual %0d", m_axis_tdata);
        end else begin
          want_len = length_q.pop_front();
          lengths_checked++;
          if (m_axis_tdata !== want_len) begin
            errors++;
            $error("match_length: expected %0d, actual %0d", want_len, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_item(op_t'(s_axis_tuser), s_axis_tdata[5:0], s_axis_tdata[13:6],
                   s_axis_tdata[19:14], s_axis_tdata[20]);
      if (psel && penable && pready && paddr[2] == REG_START) begin
        if (pwrite) begin
          start_cfg = pwdata[STATE_W-1:0];
          rewind_run();
        end else if (prdata !== APB_DW'(start_cfg)) begin
          errors++;
          $error("start register: expected %0d, actual %0d", start_cfg, prdata);
        end
      end
    end
    pending = length_q.size();
  end

endmodule

// File: tb/dfa_longest_prefix_match_core_test.sv
// Top of the matcher testbench: clock, reset, stream and APB stimulus, watchdog, verdict.
// Depends on dlpm_pkg, dfa_longest_prefix_match_core and dlpm_checker.
module dfa_longest_prefix_match_core_test;
  import dlpm_pkg::*;

  localparam int LOOP_BYTES   = 40;     // live bytes on a self-looping accepting state
  localparam int HOLD_CYCLES  = 400;    // receiver hold-off, long enough to back up the input
  localparam int SETTLE_CYCLES = 8;     // covers a live byte's table and accept-flag reads, with margin on top
  localparam int STALL_LIMIT  = 40000;  // well above the clearing sweep, which runs without a transfer
  localparam int PHASE_ITEMS  = 340;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [5:0] state_index, [13:6] symbol, [19:14] next_state, [20] entry_valid, [23:21] zero
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  // [1:0] operation
  logic [OP_W-1:0]      s_axis_tuser = OP_WR_TRANS;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [15:0] match_length
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  int n_errors;
  int n_pending;
  int n_checked;
  int items_sent;
  int tx_idle_pct = 28;
  int rx_idle_pct = 84;
  int hold_reqs;

  dfa_longest_prefix_match_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  dlpm_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .errors          (n_errors),
    .pending         (n_pending),
    .lengths_checked (n_checked)
  );

  always #2 clk = ~clk;

  function automatic logic [STATE_W-1:0] rnd_state();
    return STATE_W'($urandom_range(63));
  endfunction

  function automatic logic [SYMBOL_W-1:0] rnd_byte();
    return SYMBOL_W'($urandom_range(255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(1));
  endfunction

  // One input transfer. Called at a falling edge, returns at a falling edge with tvalid low;
  // the next call raises it again in the same step unless its idle draw holds it low, so back-to-back items see no gap.
  task automatic send_item(input op_t op, input logic [STATE_W-1:0] st,
                           input logic [SYMBOL_W-1:0] sym, input logic [STATE_W-1:0] nxt,
                           input logic valid);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {3'b000, valid, nxt, sym, st};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // Setup cycle, then access cycle; register 0 sits at byte address 0.
  task automatic apb_access(input logic write, input logic [STATE_W-1:0] value);
    paddr   = {REG_START, 2'b00};
    pwdata  = APB_DW'(value);
    pwrite  = write;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_results();
    while (n_pending != 0) @(negedge clk);
  endtask

  // Match bytes produce no result, so the block may still be stepping after the
  // last length came out: wait out SETTLE_CYCLES before touching the register.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Program a small DFA around the start state, then mostly well-formed runs over its
  // alphabet with the odd bad byte, some live table edits, and some fully random items.
  task automatic random_phase(input int n_items, input logic [STATE_W-1:0] start);
    logic [STATE_W-1:0]  pool [8];
    logic [SYMBOL_W-1:0] alpha [4];
    logic [SYMBOL_W-1:0] sym;
    int                  first;
    int                  len;
    int unsigned         r;
    bit                  held;
    bit                  paused;
    settle();
    apb_access(1'b1, start);
    apb_access(1'b0, '0);
    first = items_sent;
    pool[0] = start;
    for (int i = 1; i < 8; i++) pool[i] = rnd_state();
    alpha[0] = 8'd1;
    alpha[1] = 8'd127;
    alpha[2] = SYMBOL_W'($urandom_range(2, 126));
    alpha[3] = SYMBOL_W'($urandom_range(2, 126));
    foreach (pool[i]) begin
      foreach (alpha[j])
        send_item(OP_WR_TRANS, pool[i], alpha[j], pool[3'($urandom_range(7))],
                  $urandom_range(99) < 85);
      send_item(OP_WR_ACCEPT, pool[i], rnd_byte(), rnd_state(), rnd_bit());
    end
    held   = 1'b0;
    paused = 1'b0;
    while (items_sent - first < n_items) begin
      // halfway: receiver goes quiet while we keep pushing, so finishes back up
      if (!held && items_sent - first >= n_items / 2) begin
        held = 1'b1;
        hold_reqs++;
      end
      // three quarters in: stop and let every outstanding length drain
      if (!paused && items_sent - first >= 3 * n_items / 4) begin
        paused = 1'b1;
        wait_results();
      end
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(12);
        repeat (len) begin
          if ($urandom_range(99) < 92)
            sym = alpha[2'($urandom_range(3))];
          else
            sym = rnd_byte();  // stray byte: zero, high half, or off-alphabet
          send_item(OP_MATCH, rnd_state(), sym, rnd_state(), rnd_bit());
        end
        send_item(OP_FINISH, rnd_state(), rnd_byte(), rnd_state(), rnd_bit());
      end else if (r < 85) begin
        if ($urandom_range(3) == 0)
          send_item(OP_WR_ACCEPT, pool[3'($urandom_range(7))], rnd_byte(),
                    rnd_state(), rnd_bit());
        else
          send_item(OP_WR_TRANS, pool[3'($urandom_range(7))], alpha[2'($urandom_range(3))],
                    pool[3'($urandom_range(7))], $urandom_range(99) < 80);
      end else begin
        send_item(op_t'(2'($urandom_range(3))), rnd_state(), rnd_byte(), rnd_state(),
                  rnd_bit());
      end
    end
  endtask

  // Result side: random backpressure, plus a long hold-off on request from the stimulus.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = $urandom_range(99) >= rx_idle_pct;
      end
    end
  end

  // Watchdog: any stretch this long without a transfer on some channel is a hang.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("dfa_longest_prefix_match_core verification failed");
    $finish;
  end

  initial begin
    logic [STATE_W-1:0] mid_start;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed: reset start state (0), sender 28% idle, receiver 84% idle ----
    send_item(OP_FINISH,    6'd0,  8'd0,   6'd0,  1'b0);  // empty run -> 0
    send_item(OP_WR_TRANS,  6'd0,  8'd1,   6'd63, 1'b1);  // 0 --1--> 63
    send_item(OP_WR_TRANS,  6'd63, 8'd127, 6'd0,  1'b1);  // 63 --127--> 0
    send_item(OP_WR_TRANS,  6'd0,  8'd0,   6'd9,  1'b1);  // byte zero: dropped
    send_item(OP_WR_TRANS,  6'd0,  8'd128, 6'd9,  1'b1);  // past the alphabet: dropped
    send_item(OP_WR_TRANS,  6'd0,  8'd255, 6'd9,  1'b1);  // same, top byte
    send_item(OP_WR_ACCEPT, 6'd63, 8'd255, 6'd63, 1'b1);
    send_item(OP_MATCH,     6'd63, 8'd1,   6'd63, 1'b1);  // -> 63, accepting, best 1
    send_item(OP_MATCH,     6'd0,  8'd127, 6'd0,  1'b0);  // -> 0, not accepting
    send_item(OP_MATCH,     6'd0,  8'd1,   6'd0,  1'b0);  // -> 63, best 3
    send_item(OP_FINISH,    6'd63, 8'd255, 6'd63, 1'b1);  // -> 3
    send_item(OP_MATCH,     6'd0,  8'd1,   6'd0,  1'b0);
    send_item(OP_MATCH,     6'd0,  8'd0,   6'd0,  1'b0);  // byte zero kills the run
    send_item(OP_MATCH,     6'd0,  8'd127, 6'd0,  1'b0);  // dead: ignored
    send_item(OP_FINISH,    6'd0,  8'd0,   6'd0,  1'b0);  // -> 1
    send_item(OP_MATCH,     6'd0,  8'd128, 6'd0,  1'b0);  // high byte kills at once
    send_item(OP_FINISH,    6'd0,  8'd0,   6'd0,  1'b0);  // -> 0
    send_item(OP_MATCH,     6'd0,  8'd2,   6'd0,  1'b0);  // no entry for byte 2
    send_item(OP_FINISH,    6'd0,  8'd0,   6'd0,  1'b0);  // -> 0
    send_item(OP_WR_TRANS,  6'd0,  8'd1,   6'd63, 1'b0);  // remove 0 --1-->
    send_item(OP_WR_ACCEPT, 6'd63, 8'd0,   6'd0,  1'b0);  // 63 stops accepting
    send_item(OP_MATCH,     6'd0,  8'd1,   6'd0,  1'b0);
    send_item(OP_FINISH,    6'd0,  8'd0,   6'd0,  1'b0);  // -> 0
    send_item(OP_WR_TRANS,  6'd0,  8'd1,   6'd0,  1'b1);  // self loop on 0
    send_item(OP_WR_ACCEPT, 6'd0,  8'd0,   6'd0,  1'b1);
    send_item(OP_MATCH,     6'd0,  8'd1,   6'd0,  1'b0);  // left open: the register
    send_item(OP_MATCH,     6'd0,  8'd1,   6'd0,  1'b0);  // write below must rewind it

    // ---- long run on a self-looping accepting state, no idling either side ----
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apb_access(1'b1, 6'd63);
    apb_access(1'b0, '0);
    send_item(OP_WR_TRANS,  6'd63, 8'd120, 6'd63, 1'b1);
    send_item(OP_WR_ACCEPT, 6'd63, 8'd120, 6'd63, 1'b1);
    repeat (LOOP_BYTES) send_item(OP_MATCH, 6'd63, 8'd120, 6'd0, 1'b0);
    send_item(OP_FINISH, 6'd63, 8'd120, 6'd0, 1'b0);  // -> LOOP_BYTES
    send_item(OP_FINISH, 6'd63, 8'd120, 6'd0, 1'b0);  // fresh run -> 0

    // ---- random phases: idle mix swaps, then none; start state random, 0, 63 ----
    mid_start   = rnd_state();
    tx_idle_pct = 28;
    rx_idle_pct = 84;
    random_phase(PHASE_ITEMS, mid_start);
    tx_idle_pct = 84;
    rx_idle_pct = 28;
    random_phase(PHASE_ITEMS, 6'd0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(PHASE_ITEMS, 6'd63);

    wait_results();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("Run: %0d input transfers (directed, %0d-byte self-loop run, 3 random phases)",
             items_sent, LOOP_BYTES);
    $display("     %0d match lengths compared; start states 0, 63 and %0d; %0d-cycle hold-offs",
             n_checked, mid_start, HOLD_CYCLES);
    if (n_errors == 0 && n_pending == 0)
      $display("dfa_longest_prefix_match_core verification clean");
    else
      $display("dfa_longest_prefix_match_core verification failed");
    $finish;
  end

endmodule
